FILE: rtl/slpk_pkg.sv
// ------------------------------------------------------------------------------------------
// slpk_pkg: sample log pointer keeper package
// shared widths, codes, item types and the job word passed from front to back
// ------------------------------------------------------------------------------------------
package slpk_pkg;

    localparam int unsigned MEM_BYTES  = 8192;
    localparam int unsigned PTR_W      = $clog2(MEM_BYTES);
    localparam int unsigned PTR_X_W    = PTR_W + 1;
    localparam int unsigned MEM_TOP    = MEM_BYTES - 1;
    localparam int unsigned FULL_LIMIT = MEM_BYTES - 2;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned ADDR_W = 13;
    localparam int unsigned WORD_W = 16;

    localparam logic [PTR_W-1:0]  DATA_BASE      = PTR_W'(4);
    localparam logic [PTR_W-1:0]  PTR_STEP       = PTR_W'(2);
    localparam logic [PTR_X_W-1:0] PTR_X_STEP    = PTR_X_W'(2);
    localparam logic [ADDR_W-1:0] HDR_FIRST_ADDR = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] HDR_LAST_ADDR  = ADDR_W'(2);
    localparam logic [WORD_W-1:0] ERASED_WORD    = 16'hFFFF;

    localparam int unsigned JQ_DEPTH = 4;
    localparam int unsigned JQ_IDX_W = $clog2(JQ_DEPTH);
    localparam int unsigned JQ_CNT_W = $clog2(JQ_DEPTH + 1);
    localparam int unsigned STEP_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_SAMPLE = 3'd4
    } t_kind;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ERASE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        SEQ_NONE,
        SEQ_HDR,
        SEQ_CLEAR,
        SEQ_SAMPLE2,
        SEQ_SAMPLE3
    } t_seq;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERASE,
        OP_DATA,
        OP_HDR_FIRST,
        OP_HDR_LAST
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] sample_value;
        logic [WORD_W-1:0] stored_first_word;
        logic [WORD_W-1:0] stored_last_word;
    } t_in_item;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] word_data;
        logic              status;
        logic              logging_on;
        logic [ADDR_W-1:0] first_data_address;
        logic [ADDR_W-1:0] last_data_address;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_seq              seq;
        logic [WORD_W-1:0] value;
        logic              status;
        logic              enabled;
        logic [PTR_W-1:0]  first_ptr;
        logic [PTR_W-1:0]  last_ptr;
    } t_job;

endpackage

FILE: rtl/slpk_front.sv
// ------------------------------------------------------------------------------------------
// slpk_front: command front end
// holds the enable flag and pointers, updates them per word and queues a job
// ------------------------------------------------------------------------------------------
module slpk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slpk_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_job_wr,
    output slpk_pkg::t_job    o_job
);

    logic                         r_en;
    logic                         n_en;
    logic [slpk_pkg::PTR_W-1:0]   r_first;
    logic [slpk_pkg::PTR_W-1:0]   n_first;
    logic [slpk_pkg::PTR_W-1:0]   r_last;
    logic [slpk_pkg::PTR_W-1:0]   n_last;

    logic                         accept;
    logic                         erased;
    logic                         first_bad;
    logic                         last_bad;
    logic [slpk_pkg::PTR_W-1:0]   clamp_first;
    logic [slpk_pkg::PTR_W-1:0]   empty_mark;
    logic [slpk_pkg::PTR_W-1:0]   clamp_last;
    logic [slpk_pkg::PTR_X_W-1:0] next_sum;
    logic [slpk_pkg::PTR_W-1:0]   next_ptr;
    logic                         mem_full;
    slpk_pkg::t_seq               seq;
    logic                         status;

    assign accept = i_push && !i_q_full;

    // header check shared by init and start, plus the next pointer and full test for samples
    always_comb begin
        erased      = (i_item.stored_first_word == slpk_pkg::ERASED_WORD)
                   && (i_item.stored_last_word == slpk_pkg::ERASED_WORD);
        first_bad   = (32'(i_item.stored_first_word) < 32'(slpk_pkg::DATA_BASE))
                   || (32'(i_item.stored_first_word) > slpk_pkg::MEM_TOP);
        clamp_first = first_bad ? slpk_pkg::DATA_BASE
                                : slpk_pkg::PTR_W'(i_item.stored_first_word);
        empty_mark  = clamp_first - slpk_pkg::PTR_STEP;
        last_bad    = (32'(i_item.stored_last_word) < 32'(empty_mark))
                   || (32'(i_item.stored_last_word) > slpk_pkg::MEM_TOP);
        clamp_last  = last_bad ? empty_mark : slpk_pkg::PTR_W'(i_item.stored_last_word);
        next_sum    = {1'b0, r_last} + slpk_pkg::PTR_X_STEP;
        next_ptr    = slpk_pkg::PTR_W'(next_sum);
        mem_full    = 32'(next_sum) > slpk_pkg::FULL_LIMIT;
    end

    always_comb begin
        n_en    = r_en;
        n_first = r_first;
        n_last  = r_last;
        seq     = slpk_pkg::SEQ_NONE;
        status  = 1'b0;
        case (i_item.kind)
            slpk_pkg::KIND_INIT, slpk_pkg::KIND_START: begin
                n_en = (i_item.kind == slpk_pkg::KIND_START);
                if (erased) begin
                    n_first = slpk_pkg::DATA_BASE;
                    n_last  = slpk_pkg::DATA_BASE - slpk_pkg::PTR_STEP;
                    seq     = slpk_pkg::SEQ_HDR;
                end else begin
                    n_first = clamp_first;
                    n_last  = clamp_last;
                end
            end
            slpk_pkg::KIND_STOP: begin
                n_en = 1'b0;
            end
            slpk_pkg::KIND_CLEAR: begin
                n_en    = 1'b0;
                n_first = slpk_pkg::DATA_BASE;
                n_last  = slpk_pkg::DATA_BASE - slpk_pkg::PTR_STEP;
                seq     = slpk_pkg::SEQ_CLEAR;
            end
            slpk_pkg::KIND_SAMPLE: begin
                if (r_en) begin
                    if (mem_full) begin
                        n_en   = 1'b0;
                        status = 1'b1;
                    end else begin
                        n_last = next_ptr;
                        if (r_last < r_first) begin
                            n_first = next_ptr;
                            seq     = slpk_pkg::SEQ_SAMPLE3;
                        end else begin
                            seq = slpk_pkg::SEQ_SAMPLE2;
                        end
                    end
                end
            end
            default: begin
                seq = slpk_pkg::SEQ_NONE;
            end
        endcase
    end

    always_comb begin
        o_job_wr        = accept;
        o_job.seq       = seq;
        o_job.value     = i_item.sample_value;
        o_job.status    = status;
        o_job.enabled   = n_en;
        o_job.first_ptr = n_first;
        o_job.last_ptr  = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_first <= slpk_pkg::DATA_BASE;
            r_last  <= slpk_pkg::DATA_BASE - slpk_pkg::PTR_STEP;
        end else if (accept) begin
            r_en    <= n_en;
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

    a_first_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first >= slpk_pkg::DATA_BASE) && (32'(r_first) <= slpk_pkg::MEM_TOP))
        else $error("first pointer out of range");

    a_last_not_below_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_last) + 32'(slpk_pkg::PTR_STEP)) >= 32'(r_first))
        else $error("last pointer below empty mark");

endmodule

FILE: rtl/slpk_job_queue.sv
// ------------------------------------------------------------------------------------------
// slpk_job_queue: job queue
// short register queue between the front end and the result sequencer
// ------------------------------------------------------------------------------------------
module slpk_job_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  slpk_pkg::t_job i_job,
    input  logic           i_rd,
    output slpk_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);

    slpk_pkg::t_job                r_mem [slpk_pkg::JQ_DEPTH];
    logic [slpk_pkg::JQ_IDX_W-1:0] r_wr_ptr;
    logic [slpk_pkg::JQ_IDX_W-1:0] n_wr_ptr;
    logic [slpk_pkg::JQ_IDX_W-1:0] r_rd_ptr;
    logic [slpk_pkg::JQ_IDX_W-1:0] n_rd_ptr;
    logic [slpk_pkg::JQ_CNT_W-1:0] r_cnt;
    logic [slpk_pkg::JQ_CNT_W-1:0] n_cnt;
    logic                          do_wr;
    logic                          do_rd;

    localparam logic [slpk_pkg::JQ_IDX_W-1:0] LAST_IDX = slpk_pkg::JQ_IDX_W'(slpk_pkg::JQ_DEPTH - 1);
    localparam logic [slpk_pkg::JQ_CNT_W-1:0] FULL_CNT = slpk_pkg::JQ_CNT_W'(slpk_pkg::JQ_DEPTH);

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("job count over depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("job written into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers apart while queue empty");

endmodule

FILE: rtl/slpk_back.sv
// ------------------------------------------------------------------------------------------
// slpk_back: result sequencer
// expands the head job into one to three result words into the output register
// ------------------------------------------------------------------------------------------
module slpk_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slpk_pkg::t_job      i_job,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output slpk_pkg::t_out_item o_result
);

    logic                        r_out_vld;
    logic                        n_out_vld;
    slpk_pkg::t_out_item         r_out;
    slpk_pkg::t_out_item         n_out;
    logic [slpk_pkg::STEP_W-1:0] r_step;
    logic [slpk_pkg::STEP_W-1:0] n_step;
    slpk_pkg::t_op               op;
    logic                        fin;
    logic                        load;
    logic                        taken;

    assign taken = i_pop && r_out_vld;
    assign load  = !i_job_empty && (!r_out_vld || i_pop);

    // which word of the job goes out this cycle
    always_comb begin
        op  = slpk_pkg::OP_NONE;
        fin = 1'b1;
        case (i_job.seq)
            slpk_pkg::SEQ_NONE: begin
                op = slpk_pkg::OP_NONE;
            end
            slpk_pkg::SEQ_HDR: begin
                if (r_step == '0) begin
                    op  = slpk_pkg::OP_HDR_FIRST;
                    fin = 1'b0;
                end else begin
                    op = slpk_pkg::OP_HDR_LAST;
                end
            end
            slpk_pkg::SEQ_CLEAR: begin
                if (r_step == '0) begin
                    op  = slpk_pkg::OP_ERASE;
                    fin = 1'b0;
                end else if (r_step == slpk_pkg::STEP_W'(1)) begin
                    op  = slpk_pkg::OP_HDR_FIRST;
                    fin = 1'b0;
                end else begin
                    op = slpk_pkg::OP_HDR_LAST;
                end
            end
            slpk_pkg::SEQ_SAMPLE2: begin
                if (r_step == '0) begin
                    op  = slpk_pkg::OP_DATA;
                    fin = 1'b0;
                end else begin
                    op = slpk_pkg::OP_HDR_LAST;
                end
            end
            slpk_pkg::SEQ_SAMPLE3: begin
                if (r_step == '0) begin
                    op  = slpk_pkg::OP_DATA;
                    fin = 1'b0;
                end else if (r_step == slpk_pkg::STEP_W'(1)) begin
                    op  = slpk_pkg::OP_HDR_FIRST;
                    fin = 1'b0;
                end else begin
                    op = slpk_pkg::OP_HDR_LAST;
                end
            end
            default: begin
                op = slpk_pkg::OP_NONE;
            end
        endcase
    end

    always_comb begin
        n_out.status             = i_job.status;
        n_out.logging_on         = i_job.enabled;
        n_out.first_data_address = slpk_pkg::ADDR_W'(i_job.first_ptr);
        n_out.last_data_address  = slpk_pkg::ADDR_W'(i_job.last_ptr);
        n_out.last               = fin;
        n_out.action             = slpk_pkg::ACT_NONE;
        n_out.word_address       = '0;
        n_out.word_data          = '0;
        case (op)
            slpk_pkg::OP_ERASE: begin
                n_out.action = slpk_pkg::ACT_ERASE;
            end
            slpk_pkg::OP_DATA: begin
                n_out.action       = slpk_pkg::ACT_WRITE;
                n_out.word_address = slpk_pkg::ADDR_W'(i_job.last_ptr);
                n_out.word_data    = i_job.value;
            end
            slpk_pkg::OP_HDR_FIRST: begin
                n_out.action       = slpk_pkg::ACT_WRITE;
                n_out.word_address = slpk_pkg::HDR_FIRST_ADDR;
                n_out.word_data    = slpk_pkg::WORD_W'(i_job.first_ptr);
            end
            slpk_pkg::OP_HDR_LAST: begin
                n_out.action       = slpk_pkg::ACT_WRITE;
                n_out.word_address = slpk_pkg::HDR_LAST_ADDR;
                n_out.word_data    = slpk_pkg::WORD_W'(i_job.last_ptr);
            end
            default: begin
                n_out.action = slpk_pkg::ACT_NONE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_step    = r_step;
        if (load) begin
            n_out_vld = 1'b1;
            n_step    = fin ? '0 : r_step + 1'b1;
        end else if (taken) begin
            n_out_vld = 1'b0;
        end
    end

    assign o_job_pop = load && fin;
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_step    <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    a_step_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> !i_job_empty)
        else $error("sequencer mid job with no job queued");

    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !fin) |=> (r_step == $past(r_step) + 1'b1))
        else $error("sequencer step did not advance");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != slpk_pkg::STEP_W'(3))
        else $error("sequencer step past third word");

endmodule

FILE: rtl/sample_log_pointer_keeper.sv
// ------------------------------------------------------------------------------------------
// sample_log_pointer_keeper: linear sample log pointer keeper
// path: each command is written to a 4-deep job queue, then its result words are registered
// throughput: a command per cycle in unless full, a result word per cycle out while popped;
//   a command gives one to three result words, so the result sequencer sets the rate
// reset: synchronous; clears the enable flag, sets the pointers to 4 and 2, empties the queue
// ------------------------------------------------------------------------------------------
module sample_log_pointer_keeper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  slpk_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output slpk_pkg::t_out_item o_result
);

    logic           job_wr;
    slpk_pkg::t_job job_in;
    slpk_pkg::t_job job_head;
    logic           job_empty;
    logic           job_full;
    logic           job_pop;

    slpk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (job_full),
        .o_job_wr (job_wr),
        .o_job    (job_in)
    );

    slpk_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_job   (job_in),
        .i_rd    (job_pop),
        .o_head  (job_head),
        .o_empty (job_empty),
        .o_full  (job_full)
    );

    slpk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    assign full = job_full;

endmodule
